FILE: hw/rtl/interval_load_capacity_check_core_assert.svh
// assertion macros shared by the checker
`ifndef INTERVAL_LOAD_CAPACITY_CHECK_CORE_ASSERT_SVH
`define INTERVAL_LOAD_CAPACITY_CHECK_CORE_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define ILCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ilcc check failed");

// next-cycle implication, sampled on aclk, off while in reset
`define ILCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ilcc check failed");

`endif

FILE: hw/rtl/ilcc_pkg.sv
package ilcc_pkg;

    localparam int MASS_W        = 16;
    localparam int TIME_W        = 31;
    localparam int CAP_W         = 24;
    localparam int MAX_ITEMS_DEF = 128;
    localparam int IN_TDATA_W    = 80;
    localparam int OUT_TDATA_W   = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 24'd150;

    // one stored interval, mass in the low bits as on the input beat
    typedef struct packed {
        logic [TIME_W-1:0] end_time;
        logic [TIME_W-1:0] begin_time;
        logic [MASS_W-1:0] mass;
    } entry_t;

endpackage

FILE: hw/rtl/interval_load_capacity_check_core.sv
// interval load capacity check
// s_axis carries one weighted interval per beat: mass, begin time (inclusive),
// end time (exclusive); tlast closes the set and starts the check.
// intervals load at one beat per cycle into an on-chip memory of MAX_ITEMS
// entries; beats beyond that are dropped and flagged as overflow.
// after the last beat the block drops s_axis_tready and walks the stored set:
// for each non-empty interval it reads every entry through the single read
// port and sums the mass covering that interval's begin time, then compares
// the sum with the capacity register, ending early on the first excess.
// one m_axis beat per set: ok and overflow. it holds until m_axis_tready; the
// next set is taken only after that beat is delivered.
// cfg_wr_en writes the capacity register; write it while the block is idle.
// reset (aresetn low, synchronous) empties the set, clears overflow and sets
// capacity to 150; stored entries need no clearing.
module interval_load_capacity_check_core #(
    parameter int MAX_ITEMS = ilcc_pkg::MAX_ITEMS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ilcc_pkg::CAP_W-1:0]     cfg_wr_data,   // capacity
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // mass[15:0], begin_time[46:16], end_time[77:47], zero[79:78]
    input  logic [ilcc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // ok[0], overflow[1], zero[7:2]
    output logic [ilcc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import ilcc_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int LOAD_W = MASS_W + CNT_W;
    localparam int CMP_W  = (LOAD_W > CAP_W) ? LOAD_W : CAP_W;

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_OUTER  = 3'd1;
    localparam logic [2:0] S_OLATCH = 3'd2;
    localparam logic [2:0] S_INNER  = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_CMP    = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic              pv_reg, pv_next;
    logic [TIME_W-1:0] t_reg, t_next;
    logic [LOAD_W-1:0] load_reg, load_next;
    logic              ok_reg, ok_next;
    logic [CAP_W-1:0]  cap_reg;

    entry_t            mem [MAX_ITEMS];
    entry_t            rd_data_reg;
    entry_t            wr_entry;
    logic              wr_en;
    logic [ADDR_W-1:0] rd_addr;

    logic              s_acc;
    logic              hit;
    logic [LOAD_W-1:0] acc_sum;
    logic              last_i;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == S_RESULT);
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, ovf_reg, ok_reg};

    assign wr_entry = entry_t'(s_axis_tdata[3 * 0 + MASS_W + 2 * TIME_W - 1:0]);
    assign wr_en    = s_acc && (count_reg < CNT_W'(MAX_ITEMS));
    assign rd_addr  = (state_reg == S_OUTER) ? i_reg[ADDR_W-1:0] : j_reg[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[ADDR_W-1:0]] <= wr_entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // covering test for the entry read last cycle against the probe time
    assign hit     = (rd_data_reg.begin_time <= t_reg) && (t_reg < rd_data_reg.end_time);
    assign acc_sum = (pv_reg && hit) ? load_reg + LOAD_W'(rd_data_reg.mass) : load_reg;
    assign last_i  = (i_reg == count_reg - CNT_W'(1));

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pv_next    = pv_reg;
        t_next     = t_reg;
        load_next  = load_reg;
        ok_next    = ok_reg;
        unique case (state_reg)
            S_LOAD: begin
                if (s_acc) begin
                    if (wr_en) begin
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        i_next     = '0;
                        state_next = S_OUTER;
                    end
                end
            end
            S_OUTER: begin
                state_next = S_OLATCH;
            end
            S_OLATCH: begin
                if (rd_data_reg.end_time <= rd_data_reg.begin_time) begin
                    // empty interval adds no load anywhere
                    if (last_i) begin
                        ok_next    = 1'b1;
                        state_next = S_RESULT;
                    end else begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = S_OUTER;
                    end
                end else begin
                    t_next     = rd_data_reg.begin_time;
                    j_next     = '0;
                    load_next  = '0;
                    pv_next    = 1'b0;
                    state_next = S_INNER;
                end
            end
            S_INNER: begin
                load_next = acc_sum;
                pv_next   = 1'b1;
                j_next    = j_reg + CNT_W'(1);
                if (j_reg == count_reg - CNT_W'(1)) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                load_next  = acc_sum;
                state_next = S_CMP;
            end
            S_CMP: begin
                if (CMP_W'(load_reg) > CMP_W'(cap_reg)) begin
                    ok_next    = 1'b0;
                    state_next = S_RESULT;
                end else if (last_i) begin
                    ok_next    = 1'b1;
                    state_next = S_RESULT;
                end else begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_OUTER;
                end
            end
            S_RESULT: begin
                if (m_axis_tready) begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            pv_reg    <= 1'b0;
            cap_reg   <= CAP_RESET;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            pv_reg    <= pv_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        t_reg    <= t_next;
        load_reg <= load_next;
        ok_reg   <= ok_next;
    end

endmodule

FILE: hw/rtl/ilcc_checker.sv
`include "interval_load_capacity_check_core_assert.svh"

module ilcc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // a pending result holds until taken
    `ILCC_ASSERT_NEXT(a_res_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // no new interval is taken while a result waits
    `ILCC_ASSERT_NOW(a_no_in_with_res, m_axis_tvalid, !s_axis_tready)

    // loading continues after a beat that does not close the set
    `ILCC_ASSERT_NEXT(a_keep_loading, s_axis_tvalid && s_axis_tready && !s_axis_tlast, s_axis_tready && !m_axis_tvalid)

    // closing beat starts the check: input stalls, result not yet out
    `ILCC_ASSERT_NEXT(a_check_starts, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready && !m_axis_tvalid)

    // pad bits of the result stay zero
    `ILCC_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[7:2] == 6'd0)

endmodule

bind interval_load_capacity_check_core ilcc_checker u_ilcc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
